[rtl/rfrc_pkg.sv]
// rfrc_pkg: constants, codes and the crc-16/modbus byte fold of the radar frame receiver
// no dependencies
`default_nettype none

package rfrc_pkg;

    // item opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_HEADER  = 2'd0;
    localparam logic [1:0] REG_ACTIVE  = 2'd1;
    localparam logic [1:0] REG_PASSIVE = 2'd2;
    localparam logic [1:0] REG_TIMEOUT = 2'd3;

    // configuration reset values
    localparam logic [7:0] HEADER_RST  = 8'h55;
    localparam logic [7:0] ACTIVE_RST  = 8'h04;
    localparam logic [7:0] PASSIVE_RST = 8'h03;
    localparam logic [9:0] TIMEOUT_RST = 10'd150;

    // frame kinds
    localparam logic [2:0] KIND_CRC_ERR  = 3'd0;
    localparam logic [2:0] KIND_ENV      = 3'd1;
    localparam logic [2:0] KIND_APPROACH = 3'd2;
    localparam logic [2:0] KIND_FALL     = 3'd3;
    localparam logic [2:0] KIND_OTHER    = 3'd4;

    // environment labels
    localparam logic [1:0] ENV_UNOCCUPIED = 2'd0;
    localparam logic [1:0] ENV_STATIONARY = 2'd1;
    localparam logic [1:0] ENV_MOVING     = 2'd2;
    localparam logic [1:0] ENV_OTHER      = 2'd3;

    // approach states
    localparam logic [1:0] APPR_NONE  = 2'd0;
    localparam logic [1:0] APPR_CLOSE = 2'd1;
    localparam logic [1:0] APPR_AWAY  = 2'd2;

    // fall states
    localparam logic [1:0] FALL_SUSPECT = 2'd0;
    localparam logic [1:0] FALL_REAL    = 2'd1;
    localparam logic [1:0] FALL_NONE    = 2'd2;

    // protocol bytes
    localparam logic [7:0] ADDR_STATUS   = 8'h03;
    localparam logic [7:0] ADDR_ENV      = 8'h05;
    localparam logic [7:0] ADDR_APPROACH = 8'h07;
    localparam logic [7:0] FUNC_FALL     = 8'h06;
    localparam logic [7:0] ADDR_FALL     = 8'h01;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [16:0] MIN_FRAME = 17'd8;
    localparam logic [9:0]  IDLE_MAX  = 10'd1023;

    // reflected crc-16 update over one byte, eight shift steps
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int j = 0; j < 8; j++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/radar_frame_receiver_crc16_top.sv]
// radar_frame_receiver_crc16_top: length-prefixed radar frame parser with crc-16/modbus check
// depends on rfrc_pkg
`default_nettype none

// Takes one item per clock: a received uart byte or a one millisecond tick.
// The receiver hunts for the header byte, reads a 16-bit little-endian length L
// and closes the frame after 1+L bytes. A closed frame gives one result: a crc
// error (frame under 8 bytes or crc mismatch) or a classified report
// (environment, approach, fall, other). Frames whose length field is below 2,
// and partial frames idle for more ticks than the timeout register, are dropped
// without a result. Each item is processed in the cycle it is accepted; the
// result appears in the output register on the next cycle. The sustained rate
// is one item per clock, set by the single output register: input stall is
// raised only while that register holds a result and the output is stalled.
// Configuration writes are always ready and must only be made while idle.
module radar_frame_receiver_crc16_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [9:0]  i_cfg_data,
    // input items
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_opcode,
    input  wire logic [7:0]  i_byte_value,
    // result items
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_frame_kind,
    output logic [7:0]       o_func_code,
    output logic [7:0]       o_addr_one,
    output logic [7:0]       o_addr_two,
    output logic [15:0]      o_payload_len,
    output logic             o_occupied,
    output logic [1:0]       o_env_class,
    output logic [1:0]       o_approach_dir,
    output logic [1:0]       o_fall_status,
    output logic             o_fall_real
);
    import rfrc_pkg::*;

    // configuration
    logic [7:0]  r_cfg_header;
    logic [7:0]  r_cfg_active;
    logic [7:0]  r_cfg_passive;
    logic [9:0]  r_cfg_timeout;

    // frame state
    logic        r_in_frame,   n_in_frame;
    logic [16:0] r_byte_count, n_byte_count;
    logic [15:0] r_frame_len,  n_frame_len;
    logic [15:0] r_crc,        n_crc;
    logic [7:0]  r_tail0,      n_tail0;
    logic [7:0]  r_tail1,      n_tail1;
    logic [7:0]  r_func,       n_func;
    logic [7:0]  r_addr1,      n_addr1;
    logic [7:0]  r_addr2,      n_addr2;
    logic [7:0]  r_data0,      n_data0;
    logic [7:0]  r_data1,      n_data1;
    logic [7:0]  r_data2,      n_data2;
    logic [9:0]  r_idle_ms,    n_idle_ms;

    // result register
    logic        r_out_valid;
    logic [2:0]  r_kind,       n_kind;
    logic [15:0] r_plen,       n_plen;
    logic        r_occupied,   n_occupied;
    logic [1:0]  r_env_class,  n_env_class;
    logic [1:0]  r_appr,       n_appr;
    logic [1:0]  r_fall,       n_fall;
    logic        r_fall_real,  n_fall_real;
    logic [7:0]  r_o_func,     r_o_addr1,    r_o_addr2;

    logic        in_acc;
    logic        emit;
    logic        clear;
    logic [16:0] expected;
    logic        func_match;

    // result register full and held back by the consumer
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_frame   = r_in_frame;
        n_byte_count = r_byte_count;
        n_frame_len  = r_frame_len;
        n_crc        = r_crc;
        n_tail0      = r_tail0;
        n_tail1      = r_tail1;
        n_func       = r_func;
        n_addr1      = r_addr1;
        n_addr2      = r_addr2;
        n_data0      = r_data0;
        n_data1      = r_data1;
        n_data2      = r_data2;
        n_idle_ms    = r_idle_ms;
        emit         = 1'b0;
        clear        = 1'b0;
        expected     = 17'd0;

        if (in_acc) begin
            if (i_opcode == OP_TICK) begin
                n_idle_ms = (r_idle_ms == IDLE_MAX) ? r_idle_ms : r_idle_ms + 10'd1;
                if (r_in_frame && (n_idle_ms > r_cfg_timeout)) begin
                    clear = 1'b1;
                end
            end else begin
                n_idle_ms = 10'd0;
                if (r_in_frame || (i_byte_value == r_cfg_header)) begin
                    n_in_frame = 1'b1;
                    // the last two bytes stay out of the crc until a later byte arrives
                    if (r_byte_count >= 17'd2) begin
                        n_crc = crc_fold(r_crc, r_tail0);
                    end
                    n_tail0 = r_tail1;
                    n_tail1 = i_byte_value;
                    case (r_byte_count)
                        17'd1:   n_frame_len = {8'h00, i_byte_value};
                        17'd2:   n_frame_len = {i_byte_value, r_frame_len[7:0]};
                        17'd3:   n_func  = i_byte_value;
                        17'd4:   n_addr1 = i_byte_value;
                        17'd5:   n_addr2 = i_byte_value;
                        17'd6:   n_data0 = i_byte_value;
                        17'd7:   n_data1 = i_byte_value;
                        17'd8:   n_data2 = i_byte_value;
                        default: ;
                    endcase
                    n_byte_count = r_byte_count + 17'd1;
                    if (n_byte_count >= 17'd3) begin
                        expected = {1'b0, n_frame_len} + 17'd1;
                        if (n_byte_count == expected) begin
                            emit  = 1'b1;
                            clear = 1'b1;
                        end else if (n_byte_count > expected) begin
                            // length field too short to cover itself
                            clear = 1'b1;
                        end
                    end
                end
            end
        end

        // result fields, from the frame as it stands after this byte
        n_plen      = (n_frame_len >= 16'd5) ? n_frame_len - 16'd5 : 16'd0;
        n_kind      = KIND_OTHER;
        n_occupied  = 1'b0;
        n_env_class = ENV_UNOCCUPIED;
        n_appr      = APPR_NONE;
        n_fall      = FALL_SUSPECT;
        n_fall_real = 1'b0;
        func_match  = (n_func == r_cfg_active) || (n_func == r_cfg_passive);
        if ((n_byte_count < MIN_FRAME) || (n_crc != {n_tail1, n_tail0})) begin
            n_kind = KIND_CRC_ERR;
        end else if (func_match && n_addr1 == ADDR_STATUS && n_addr2 == ADDR_ENV
                     && n_plen >= 16'd3) begin
            n_kind      = KIND_ENV;
            n_occupied  = 1'b1;
            n_env_class = ENV_OTHER;
            if (n_data0 == 8'h00 && n_data1 == 8'hFF && n_data2 == 8'hFF) begin
                n_occupied  = 1'b0;
                n_env_class = ENV_UNOCCUPIED;
            end else if (n_data0 == 8'h01 && n_data1 == 8'h00 && n_data2 == 8'hFF) begin
                n_env_class = ENV_STATIONARY;
            end else if (n_data0 == 8'h01 && n_data1 == 8'h01 && n_data2 == 8'h01) begin
                n_env_class = ENV_MOVING;
            end
        end else if (func_match && n_addr1 == ADDR_STATUS && n_addr2 == ADDR_APPROACH
                     && n_plen >= 16'd1) begin
            n_kind = KIND_APPROACH;
            if (n_data0 == 8'h02) begin
                n_appr = APPR_CLOSE;
            end else if (n_data0 == 8'h03) begin
                n_appr = APPR_AWAY;
            end
        end else if (n_func == FUNC_FALL && n_addr1 == ADDR_FALL && n_plen >= 16'd1) begin
            n_kind = KIND_FALL;
            if (n_data0 == 8'h00) begin
                n_fall = FALL_SUSPECT;
            end else if (n_data0 == 8'h01) begin
                n_fall      = FALL_REAL;
                n_fall_real = 1'b1;
            end else begin
                n_fall = FALL_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_header  <= HEADER_RST;
            r_cfg_active  <= ACTIVE_RST;
            r_cfg_passive <= PASSIVE_RST;
            r_cfg_timeout <= TIMEOUT_RST;
            r_in_frame    <= 1'b0;
            r_byte_count  <= 17'd0;
            r_frame_len   <= 16'd0;
            r_crc         <= CRC_INIT;
            r_tail0       <= 8'h00;
            r_tail1       <= 8'h00;
            r_func        <= 8'h00;
            r_addr1       <= 8'h00;
            r_addr2       <= 8'h00;
            r_data0       <= 8'h00;
            r_data1       <= 8'h00;
            r_data2       <= 8'h00;
            r_idle_ms     <= 10'd0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_HEADER:  r_cfg_header  <= i_cfg_data[7:0];
                    REG_ACTIVE:  r_cfg_active  <= i_cfg_data[7:0];
                    REG_PASSIVE: r_cfg_passive <= i_cfg_data[7:0];
                    REG_TIMEOUT: r_cfg_timeout <= i_cfg_data;
                    default:     ;
                endcase
            end
            r_idle_ms <= n_idle_ms;
            if (clear) begin
                r_in_frame   <= 1'b0;
                r_byte_count <= 17'd0;
                r_frame_len  <= 16'd0;
                r_crc        <= CRC_INIT;
                r_tail0      <= 8'h00;
                r_tail1      <= 8'h00;
                r_func       <= 8'h00;
                r_addr1      <= 8'h00;
                r_addr2      <= 8'h00;
                r_data0      <= 8'h00;
                r_data1      <= 8'h00;
                r_data2      <= 8'h00;
            end else begin
                r_in_frame   <= n_in_frame;
                r_byte_count <= n_byte_count;
                r_frame_len  <= n_frame_len;
                r_crc        <= n_crc;
                r_tail0      <= n_tail0;
                r_tail1      <= n_tail1;
                r_func       <= n_func;
                r_addr1      <= n_addr1;
                r_addr2      <= n_addr2;
                r_data0      <= n_data0;
                r_data1      <= n_data1;
                r_data2      <= n_data2;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded only with a new item
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind      <= n_kind;
            r_o_func    <= n_func;
            r_o_addr1   <= n_addr1;
            r_o_addr2   <= n_addr2;
            r_plen      <= n_plen;
            r_occupied  <= n_occupied;
            r_env_class <= n_env_class;
            r_appr      <= n_appr;
            r_fall      <= n_fall;
            r_fall_real <= n_fall_real;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_kind   = r_kind;
    assign o_func_code    = r_o_func;
    assign o_addr_one     = r_o_addr1;
    assign o_addr_two     = r_o_addr2;
    assign o_payload_len  = r_plen;
    assign o_occupied     = r_occupied;
    assign o_env_class    = r_env_class;
    assign o_approach_dir = r_appr;
    assign o_fall_status  = r_fall;
    assign o_fall_real    = r_fall_real;

`ifndef SYNTHESIS
    // hunting state holds no partial frame
    a_hunt_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_byte_count == 17'd0 && r_crc == CRC_INIT))
        else $error("frame state not clear while hunting");

    // an open frame never runs past its declared length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_frame && r_byte_count >= 17'd3)
            |-> (r_byte_count < {1'b0, r_frame_len} + 17'd1))
        else $error("byte count past frame end");

    // a real fall flag only comes with a fall report
    a_fall_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_fall_real)
            |-> (o_frame_kind == KIND_FALL && o_fall_status == FALL_REAL))
        else $error("fall flag on wrong kind");

    // environment fields are zero outside environment reports
    a_env_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_kind != KIND_ENV)
            |-> (!o_occupied && o_env_class == ENV_UNOCCUPIED))
        else $error("environment fields set on other kind");

    // an empty result register never holds back the input
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> !o_in_stall)
        else $error("input stalled with empty result register");
`endif

endmodule

`default_nettype wire
